FILE: rtl/ghc_pkg.sv
// ----------------------------------------------------------------------------
// ghc_pkg
// Types and constants shared by the greenhouse hysteresis controller.
// ----------------------------------------------------------------------------
package ghc_pkg;

	// Shift limits and day length in seconds
	localparam logic [16:0] DAY_START_S     = 17'd25200;
	localparam logic [16:0] NIGHT_START_S   = 17'd68400;
	localparam logic [17:0] SECONDS_PER_DAY = 18'd86400;
	localparam logic [17:0] TIME_MAX_S      = 18'd131071;

	// Hysteresis bands in tenths of a unit
	localparam logic [10:0] HYST_SOIL     = 11'd10;
	localparam logic [12:0] HYST_FAN      = 13'd10;
	localparam logic [12:0] HYST_HEATER   = 13'd3;
	localparam logic [10:0] HYST_HUMIDITY = 11'd30;

	localparam logic [6:0] FULL_DRIVE = 7'd100;

	// Register indexes
	typedef enum logic [2:0] {
		REG_DAY_CLIMATE   = 3'd0,
		REG_NIGHT_CLIMATE = 3'd1,
		REG_DAY_LIGHT     = 3'd2,
		REG_NIGHT_LIGHT   = 3'd3,
		REG_IRR_WAIT      = 3'd4,
		REG_IRR_ON        = 3'd5,
		REG_IRR_DEAD      = 3'd6,
		REG_LIGHT_ON_TIME = 3'd7
	} ghc_reg_t;

	localparam int CFG_DATA_W = 33;

	// Register reset values
	localparam logic [30:0] CLIMATE_RESET   = 31'd262861300;
	localparam logic [32:0] LIGHT_RESET     = 33'd1310763200;
	localparam logic [26:0] IRR_WAIT_RESET  = 27'd300000;
	localparam logic [26:0] IRR_ON_RESET    = 27'd10000;
	localparam logic [26:0] IRR_DEAD_RESET  = 27'd3600000;
	localparam logic [16:0] ON_TIME_RESET   = 17'd25200;
	localparam logic [16:0] OFF_TIME_RESET  = 17'd72000;

	typedef struct packed {
		logic [30:0] day_climate;
		logic [30:0] night_climate;
		logic [32:0] day_light;
		logic [32:0] night_light;
		logic [26:0] irrigation_wait_ms;
		logic [26:0] irrigation_on_ms;
		logic [26:0] irrigation_dead_ms;
		logic [16:0] light_on_time_s;
	} ghc_cfg_t;

	typedef struct packed {
		logic [6:0]         manual_heater;
		logic [6:0]         manual_diffuser;
		logic [6:0]         manual_fan;
		logic [15:0]        manual_led;
		logic [6:0]         manual_valve;
		logic               auto_mode;
		logic [9:0]         air_humidity;
		logic signed [10:0] air_temperature;
		logic [9:0]         soil_moisture;
		logic [31:0]        time_ms;
		logic [16:0]        time_of_day_s;
	} ghc_item_t;

	typedef struct packed {
		logic        is_day;
		logic [6:0]  heater_level;
		logic [6:0]  diffuser_level;
		logic [6:0]  fan_level;
		logic [15:0] led_level;
		logic [6:0]  valve_level;
	} ghc_result_t;

endpackage

FILE: rtl/ghc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ghc_cfg_regs
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module ghc_cfg_regs
	import ghc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output ghc_cfg_t              cfg
);

	ghc_cfg_t cfg_q;

	// Store the addressed register on a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.day_climate        <= CLIMATE_RESET;
			cfg_q.night_climate      <= CLIMATE_RESET;
			cfg_q.day_light          <= LIGHT_RESET;
			cfg_q.night_light        <= LIGHT_RESET;
			cfg_q.irrigation_wait_ms <= IRR_WAIT_RESET;
			cfg_q.irrigation_on_ms   <= IRR_ON_RESET;
			cfg_q.irrigation_dead_ms <= IRR_DEAD_RESET;
			cfg_q.light_on_time_s    <= ON_TIME_RESET;
		end else if (cfg_we) begin
			unique case (ghc_reg_t'(cfg_addr))
				REG_DAY_CLIMATE:   cfg_q.day_climate        <= cfg_wdata[30:0];
				REG_NIGHT_CLIMATE: cfg_q.night_climate      <= cfg_wdata[30:0];
				REG_DAY_LIGHT:     cfg_q.day_light          <= cfg_wdata[32:0];
				REG_NIGHT_LIGHT:   cfg_q.night_light        <= cfg_wdata[32:0];
				REG_IRR_WAIT:      cfg_q.irrigation_wait_ms <= cfg_wdata[26:0];
				REG_IRR_ON:        cfg_q.irrigation_on_ms   <= cfg_wdata[26:0];
				REG_IRR_DEAD:      cfg_q.irrigation_dead_ms <= cfg_wdata[26:0];
				REG_LIGHT_ON_TIME: cfg_q.light_on_time_s    <= cfg_wdata[16:0];
				default:           cfg_q                    <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/ghc_core.sv
// ----------------------------------------------------------------------------
// ghc_core
// Control state and the per-tick update: shift tracking, light window,
// irrigation timing and the bang-bang climate loops.
// ----------------------------------------------------------------------------
module ghc_core
	import ghc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  ghc_item_t   item,
	input  ghc_cfg_t    cfg,
	output ghc_result_t result
);

	logic        prev_shift_q;
	logic        window_armed_q;
	logic        window_wrapped_q;
	logic [16:0] light_off_q;
	logic        dry_pending_q;
	logic        pump_on_q;
	logic        dead_q;
	logic [31:0] mark_q;
	logic        fan_on_q;
	logic        diffuser_on_q;
	logic        heater_on_q;

	logic        day;
	logic        clr;
	logic        armed_e, dry_e, pump_e, dead_e, fan_e, diff_e, heat_e;
	logic [30:0] clim;
	logic [32:0] lite;
	logic [9:0]  sp_soil;
	logic [9:0]  sp_hum;
	logic signed [12:0] sp_temp;
	logic signed [12:0] temp;
	logic [17:0] off_sum;
	logic [17:0] off_wrap;
	logic        wrap_arm;
	logic [16:0] off_sat;
	logic        wrapped_e;
	logic [16:0] light_off_e;
	logic        wrapped_n;
	logic        light;
	logic        dry;
	logic [31:0] elapsed;
	logic        m1_now, m2_now, m3_now;
	logic [31:0] dt1, dt2, dt3;
	logic        pump_start, pump1, pump_stop, dead1, dead_clr;
	logic        pump_n, dead_n;
	logic        fan_n, diff_n, heat_n;

	// Shift and flag clearing
	assign day = (item.time_of_day_s >= DAY_START_S) && (item.time_of_day_s <= NIGHT_START_S);
	assign clr = (prev_shift_q != day) || !item.auto_mode;

	assign armed_e = window_armed_q & ~clr;
	assign dry_e   = dry_pending_q & ~clr;
	assign pump_e  = pump_on_q & ~clr;
	assign dead_e  = dead_q & ~clr;
	assign fan_e   = fan_on_q & ~clr;
	assign diff_e  = diffuser_on_q & ~clr;
	assign heat_e  = heater_on_q & ~clr;

	// Setpoints of the current shift
	assign clim    = day ? cfg.day_climate : cfg.night_climate;
	assign lite    = day ? cfg.day_light : cfg.night_light;
	assign sp_soil = clim[9:0];
	assign sp_hum  = clim[19:10];
	assign sp_temp = {{2{clim[30]}}, clim[30:20]};
	assign temp    = {{2{item.air_temperature[10]}}, item.air_temperature};

	// Arm the light window on the first auto tick of a shift
	assign off_sum  = {1'b0, cfg.light_on_time_s} + {1'b0, lite[16:0]};
	assign wrap_arm = off_sum >= SECONDS_PER_DAY;
	assign off_wrap = wrap_arm ? (off_sum - SECONDS_PER_DAY) : off_sum;
	assign off_sat  = (off_wrap > TIME_MAX_S) ? TIME_MAX_S[16:0] : off_wrap[16:0];

	assign wrapped_e   = armed_e ? window_wrapped_q : wrap_arm;
	assign light_off_e = armed_e ? light_off_q : off_sat;

	// Light: a wrapped window holds on until the first tick before night start
	always_comb begin
		if (wrapped_e) begin
			light     = 1'b1;
			wrapped_n = !(item.time_of_day_s < NIGHT_START_S);
		end else begin
			light     = (item.time_of_day_s >= cfg.light_on_time_s) &&
			            (item.time_of_day_s <= light_off_e);
			wrapped_n = 1'b0;
		end
	end

	// Irrigation: wait, pump, dead time; a fresh mark means zero elapsed time
	assign dry = ({1'b0, item.soil_moisture} + HYST_SOIL <= {1'b0, sp_soil}) &&
	             !dead_e && !pump_e;
	assign elapsed = item.time_ms - mark_q;

	assign m1_now     = dry && !dry_e;
	assign dt1        = m1_now ? 32'd0 : elapsed;
	assign pump_start = dry && (dt1 >= {5'd0, cfg.irrigation_wait_ms});
	assign m2_now     = m1_now || pump_start;
	assign dt2        = m2_now ? 32'd0 : elapsed;
	assign pump1      = pump_e || pump_start;
	assign pump_stop  = pump1 && (dt2 >= {5'd0, cfg.irrigation_on_ms});
	assign m3_now     = m2_now || pump_stop;
	assign dt3        = m3_now ? 32'd0 : elapsed;
	assign dead1      = dead_e || pump_stop;
	assign dead_clr   = dead1 && (dt3 >= {5'd0, cfg.irrigation_dead_ms});
	assign pump_n     = pump1 && !pump_stop;
	assign dead_n     = dead1 && !dead_clr;

	// Climate loops: the off test wins over the on test
	assign fan_n  = (fan_e || (temp >= sp_temp + $signed(HYST_FAN))) && !(temp <= sp_temp);
	assign diff_n = (diff_e || (({1'b0, item.air_humidity} + HYST_HUMIDITY <= {1'b0, sp_hum})
	                && !fan_n)) && !((item.air_humidity >= sp_hum) || fan_n);
	assign heat_n = (heat_e || (temp <= sp_temp - $signed(HYST_HEATER))) && !(temp >= sp_temp);

	// Update the control state on each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_shift_q     <= 1'b0;
			window_armed_q   <= 1'b0;
			window_wrapped_q <= 1'b0;
			light_off_q      <= OFF_TIME_RESET;
			dry_pending_q    <= 1'b0;
			pump_on_q        <= 1'b0;
			dead_q           <= 1'b0;
			mark_q           <= 32'd0;
			fan_on_q         <= 1'b0;
			diffuser_on_q    <= 1'b0;
			heater_on_q      <= 1'b0;
		end else if (step) begin
			prev_shift_q <= day;
			if (item.auto_mode) begin
				window_armed_q   <= 1'b1;
				window_wrapped_q <= wrapped_n;
				light_off_q      <= light_off_e;
				dry_pending_q    <= dry;
				pump_on_q        <= pump_n;
				dead_q           <= dead_n;
				if (m3_now) begin
					mark_q <= item.time_ms;
				end
				fan_on_q      <= fan_n;
				diffuser_on_q <= diff_n;
				heater_on_q   <= heat_n;
			end else begin
				window_armed_q <= 1'b0;
				dry_pending_q  <= 1'b0;
				pump_on_q      <= 1'b0;
				dead_q         <= 1'b0;
				fan_on_q       <= 1'b0;
				diffuser_on_q  <= 1'b0;
				heater_on_q    <= 1'b0;
			end
		end
	end

	// Select automatic drive or manual pass-through
	always_comb begin
		result.is_day = day;
		if (item.auto_mode) begin
			result.valve_level    = pump_n ? FULL_DRIVE : 7'd0;
			result.led_level      = light ? lite[32:17] : 16'd0;
			result.fan_level      = fan_n ? FULL_DRIVE : 7'd0;
			result.diffuser_level = diff_n ? FULL_DRIVE : 7'd0;
			result.heater_level   = heat_n ? FULL_DRIVE : 7'd0;
		end else begin
			result.valve_level    = item.manual_valve;
			result.led_level      = item.manual_led;
			result.fan_level      = item.manual_fan;
			result.diffuser_level = item.manual_diffuser;
			result.heater_level   = item.manual_heater;
		end
	end

	// Pump and dead time never overlap
	a_pump_dead_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(pump_on_q && dead_q))
		else $error("pump and dead time active together");

	// Diffuser is locked out while the fan runs
	a_fan_diff_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(fan_on_q && diffuser_on_q))
		else $error("diffuser on while fan runs");

	// A manual tick leaves the armed, dry, pump, dead-time and heater flags cleared
	a_manual_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !item.auto_mode) |=> (!window_armed_q && !pump_on_q && !dead_q &&
		!dry_pending_q && !heater_on_q))
		else $error("flags survive a manual tick");

	// Heater and fan cannot both run
	a_fan_heat_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(fan_on_q && heater_on_q))
		else $error("fan and heater on together");

endmodule

FILE: rtl/greenhouse_hysteresis_controller.sv
// ----------------------------------------------------------------------------
// greenhouse_hysteresis_controller
// Greenhouse actuator control from time of day and climate sensor readings.
//
//   channel   dir  handshake                  payload
//   s_axis    in   s_tvalid / s_tready        s_tdata  (one control tick)
//   m_axis    out  m_tvalid / m_tready        m_tdata  (actuator levels)
//   cfg       in   cfg_we                     cfg_addr, cfg_wdata
//
// One tick per cycle sustained while the output is not stalled; a tick passes
// through the input register, then the result register, before its result is
// valid and can transfer. The state update and all compares sit in one
// combinational pass between those registers.
// Reset returns registers and control state to their defaults; no sweep.
// A stalled output holds its result, and the input register keeps accepting
// as long as the result register frees up in the same cycle.
// ----------------------------------------------------------------------------
module greenhouse_hysteresis_controller
	import ghc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// time_of_day_s[16:0], time_ms[48:17], soil_moisture[58:49],
	// air_temperature[69:59], air_humidity[79:70], auto_mode[80],
	// manual_valve[87:81], manual_led[103:88], manual_fan[110:104],
	// manual_diffuser[117:111], manual_heater[124:118], zero[127:125]
	input  logic [127:0]          s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// valve_level[6:0], led_level[22:7], fan_level[29:23],
	// diffuser_level[36:30], heater_level[43:37], is_day[44], zero[47:45]
	output logic [47:0]           m_tdata,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	ghc_cfg_t    cfg;
	ghc_item_t   item_s1;
	logic        valid_s1;
	ghc_result_t result;
	ghc_result_t result_s2;
	logic        valid_s2;
	logic        advance;

	ghc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Move a tick into the result register when it is free or drains now
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Hold the accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= ghc_item_t'(s_tdata[124:0]);
		end
	end

	ghc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'd0, result_s2};

endmodule

FILE: verif/tb_greenhouse_hysteresis_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greenhouse_hysteresis_controller
// Self-checking bench for the greenhouse hysteresis controller.
//
// Control ticks go in over the slave stream and actuator levels come out over
// the master stream. An in-bench copy of the controller state and registers
// predicts the levels of every accepted tick. A short table of directed ticks
// comes first. Random phases follow under several register settings, the
// extremes among them, and under several idling patterns. One phase holds off
// the receiver for a long stretch so that the block backs up its input.
// ----------------------------------------------------------------------------
module tb_greenhouse_hysteresis_controller;
	import ghc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int RANDOM_PER_PHASE = 356;
	localparam logic [31:0] WRAP_BASE_MS = 32'hFFFF_0000;

	typedef struct {
		ghc_item_t   tick;
		bit          typed;
		ghc_result_t want;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [127:0]          s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [47:0]           m_tdata;
	logic                  cfg_we = 1'b0;
	logic [2:0]            cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	greenhouse_hysteresis_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 0;
	end

	// Register copies and controller state of the prediction
	ghc_cfg_t    cfg_now;
	logic        st_shift, st_armed, st_wrapped;
	logic [16:0] st_off_time;
	logic        st_dry, st_pump, st_dead;
	logic [31:0] st_mark;
	logic        st_fan, st_diffuser, st_heater;

	ghc_result_t expected_levels[$];
	stim_row_t   directed_rows[$];
	int          mismatch_count = 0;
	int          idle_cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_req = 0;
	int          hold_left = 0;

	// Random tick generator state
	int          gen_tod = 30000;
	logic [31:0] gen_ms = '0;
	bit          gen_dry = 0;

	ghc_result_t got_levels, want_levels;

	function automatic void clear_control_flags();
		st_armed = 1'b0;
		st_dead = 1'b0;
		st_dry = 1'b0;
		st_heater = 1'b0;
		st_fan = 1'b0;
		st_diffuser = 1'b0;
		st_pump = 1'b0;
	endfunction

	// Advance the controller copy by one tick and return its actuator levels
	function automatic ghc_result_t climate_step(input ghc_item_t t);
		ghc_result_t r;
		logic        day, light;
		logic [30:0] clim;
		logic [32:0] lite;
		logic [31:0] off, now, since;
		int          sp_soil, sp_hum, sp_temp, soil, hum, temp;
		r = '0;
		now = t.time_ms;
		day = (t.time_of_day_s >= DAY_START_S) && (t.time_of_day_s <= NIGHT_START_S);
		if (st_shift != day || !t.auto_mode) begin
			st_shift = day;
			clear_control_flags();
		end
		if (t.auto_mode) begin
			clim = day ? cfg_now.day_climate : cfg_now.night_climate;
			lite = day ? cfg_now.day_light : cfg_now.night_light;
			sp_soil = int'(clim[9:0]);
			sp_hum = int'(clim[19:10]);
			sp_temp = $signed(clim[30:20]);
			soil = int'(t.soil_moisture);
			hum = int'(t.air_humidity);
			temp = $signed(t.air_temperature);

			// Arm the light window once per shift
			if (!st_armed) begin
				off = 32'(cfg_now.light_on_time_s) + 32'(lite[16:0]);
				if (off >= 32'(SECONDS_PER_DAY)) begin
					off = off - 32'(SECONDS_PER_DAY);
					st_wrapped = 1'b1;
				end else begin
					st_wrapped = 1'b0;
				end
				st_off_time = (off > 32'(TIME_MAX_S)) ? 17'h1FFFF : off[16:0];
				st_armed = 1'b1;
			end

			if (st_wrapped) begin
				if (t.time_of_day_s < NIGHT_START_S)
					st_wrapped = 1'b0;
				light = 1'b1;
			end else begin
				light = (t.time_of_day_s >= cfg_now.light_on_time_s) &&
					(t.time_of_day_s <= st_off_time);
			end

			// Irrigation: dry wait, pump run, dead time
			if (soil <= sp_soil - int'(HYST_SOIL) && !st_dead && !st_pump) begin
				if (!st_dry) begin
					st_dry = 1'b1;
					st_mark = now;
				end
				since = now - st_mark;
				if (since >= 32'(cfg_now.irrigation_wait_ms)) begin
					st_pump = 1'b1;
					st_mark = now;
				end
			end else begin
				st_dry = 1'b0;
			end
			since = now - st_mark;
			if (st_pump && since >= 32'(cfg_now.irrigation_on_ms)) begin
				st_pump = 1'b0;
				st_mark = now;
				st_dead = 1'b1;
			end
			since = now - st_mark;
			if (st_dead && since >= 32'(cfg_now.irrigation_dead_ms))
				st_dead = 1'b0;

			// Bang-bang loops; the off test wins
			if (temp >= sp_temp + int'(HYST_FAN)) st_fan = 1'b1;
			if (temp <= sp_temp) st_fan = 1'b0;
			if (hum <= sp_hum - int'(HYST_HUMIDITY) && !st_fan) st_diffuser = 1'b1;
			if (hum >= sp_hum || st_fan) st_diffuser = 1'b0;
			if (temp <= sp_temp - int'(HYST_HEATER)) st_heater = 1'b1;
			if (temp >= sp_temp) st_heater = 1'b0;

			r.valve_level = st_pump ? FULL_DRIVE : 7'd0;
			r.led_level = light ? lite[32:17] : 16'd0;
			r.fan_level = st_fan ? FULL_DRIVE : 7'd0;
			r.diffuser_level = st_diffuser ? FULL_DRIVE : 7'd0;
			r.heater_level = st_heater ? FULL_DRIVE : 7'd0;
		end else begin
			r.valve_level = t.manual_valve;
			r.led_level = t.manual_led;
			r.fan_level = t.manual_fan;
			r.diffuser_level = t.manual_diffuser;
			r.heater_level = t.manual_heater;
		end
		r.is_day = day;
		return r;
	endfunction

	function automatic ghc_item_t tick(input int tod, input logic [31:0] ms, input int soil,
		input int temp, input int hum, input bit auto_on, input int mv, input int ml,
		input int mf, input int md, input int mh);
		ghc_item_t t;
		t.time_of_day_s = tod[16:0];
		t.time_ms = ms;
		t.soil_moisture = soil[9:0];
		t.air_temperature = temp[10:0];
		t.air_humidity = hum[9:0];
		t.auto_mode = auto_on;
		t.manual_valve = mv[6:0];
		t.manual_led = ml[15:0];
		t.manual_fan = mf[6:0];
		t.manual_diffuser = md[6:0];
		t.manual_heater = mh[6:0];
		return t;
	endfunction

	function automatic int clamp(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic logic [30:0] pack_climate(input int soil, input int hum, input int temp);
		return {temp[10:0], hum[9:0], soil[9:0]};
	endfunction

	// Random tick: time moves forward, readings hover around the setpoints
	function automatic ghc_item_t make_tick();
		ghc_item_t   t;
		int          pick, tod, sp_soil, sp_hum, sp_temp, soil, temp, hum;
		logic [30:0] clim;
		logic [31:0] span;
		logic        day;
		pick = $urandom_range(99);
		if (pick < 4) begin
			tod = $urandom_range(131071);
		end else begin
			if (pick < 12) begin
				case ($urandom_range(5))
				0: gen_tod = 25199;
				1: gen_tod = 25200;
				2: gen_tod = 68400;
				3: gen_tod = 68401;
				4: gen_tod = cfg_now.light_on_time_s;
				default: gen_tod = st_off_time + $urandom_range(1);
				endcase
			end else begin
				gen_tod = gen_tod + $urandom_range(900);
			end
			if (gen_tod >= 86400)
				gen_tod = gen_tod - 86400;
			tod = gen_tod;
		end

		span = 32'(cfg_now.irrigation_wait_ms);
		if (32'(cfg_now.irrigation_on_ms) > span) span = 32'(cfg_now.irrigation_on_ms);
		if (32'(cfg_now.irrigation_dead_ms) > span) span = 32'(cfg_now.irrigation_dead_ms);
		if ($urandom_range(99) < 2)
			gen_ms = $urandom();
		else
			gen_ms = gen_ms + $urandom_range(span / 3 + 200);

		day = (tod >= int'(DAY_START_S)) && (tod <= int'(NIGHT_START_S));
		clim = day ? cfg_now.day_climate : cfg_now.night_climate;
		sp_soil = int'(clim[9:0]);
		sp_hum = int'(clim[19:10]);
		sp_temp = $signed(clim[30:20]);

		if ($urandom_range(99) < 6)
			gen_dry = !gen_dry;
		if ($urandom_range(99) < 10)
			soil = $urandom_range(1000);
		else if (gen_dry)
			soil = sp_soil - int'(HYST_SOIL) - int'($urandom_range(20));
		else
			soil = sp_soil - 12 + int'($urandom_range(30));
		if ($urandom_range(99) < 10)
			temp = int'($urandom_range(1250)) - 400;
		else
			temp = sp_temp - 16 + int'($urandom_range(32));
		if ($urandom_range(99) < 10)
			hum = $urandom_range(1000);
		else
			hum = sp_hum - 40 + int'($urandom_range(50));

		t = tick(tod, gen_ms, clamp(soil, 0, 1000), clamp(temp, -400, 850),
			clamp(hum, 0, 1000), $urandom_range(99) < 93, $urandom_range(100),
			$urandom_range(65535), $urandom_range(100), $urandom_range(100),
			$urandom_range(100));
		return t;
	endfunction

	// Offer one tick, hold it until the transfer, then record its levels
	task automatic send_tick(input ghc_item_t t, input bit typed, input ghc_result_t want);
		ghc_result_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, t};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pred = climate_step(t);
		expected_levels.push_back(typed ? want : pred);
	endtask

	task automatic run_random(input int count, input int hold_at);
		for (int n = 0; n < count; n++) begin
			if (n == hold_at)
				hold_req = 1;
			send_tick(make_tick(), 0, '0);
		end
	endtask

	// Drop valid and wait until every result has come back
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_levels.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input ghc_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
		REG_DAY_CLIMATE:   cfg_now.day_climate = value[30:0];
		REG_NIGHT_CLIMATE: cfg_now.night_climate = value[30:0];
		REG_DAY_LIGHT:     cfg_now.day_light = value[32:0];
		REG_NIGHT_LIGHT:   cfg_now.night_light = value[32:0];
		REG_IRR_WAIT:      cfg_now.irrigation_wait_ms = value[26:0];
		REG_IRR_ON:        cfg_now.irrigation_on_ms = value[26:0];
		REG_IRR_DEAD:      cfg_now.irrigation_dead_ms = value[26:0];
		default:           cfg_now.light_on_time_s = value[16:0];
		endcase
	endtask

	task automatic apply_settings(input ghc_cfg_t c);
		write_reg(REG_DAY_CLIMATE, 33'(c.day_climate));
		write_reg(REG_NIGHT_CLIMATE, 33'(c.night_climate));
		write_reg(REG_DAY_LIGHT, c.day_light);
		write_reg(REG_NIGHT_LIGHT, c.night_light);
		write_reg(REG_IRR_WAIT, 33'(c.irrigation_wait_ms));
		write_reg(REG_IRR_ON, 33'(c.irrigation_on_ms));
		write_reg(REG_IRR_DEAD, 33'(c.irrigation_dead_ms));
		write_reg(REG_LIGHT_ON_TIME, 33'(c.light_on_time_s));
		cfg_we <= 1'b0;
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_OFF_CYCLES;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Compare each result transfer with the oldest expected levels
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_levels = m_tdata[44:0];
			if (expected_levels.size() == 0) begin
				if (mismatch_count < 10)
					$display("unexpected result: valve %0d led %0d fan %0d diff %0d heat %0d day %0d",
						got_levels.valve_level, got_levels.led_level, got_levels.fan_level,
						got_levels.diffuser_level, got_levels.heater_level, got_levels.is_day);
				mismatch_count++;
			end else begin
				want_levels = expected_levels.pop_front();
				if (got_levels.valve_level !== want_levels.valve_level ||
					got_levels.led_level !== want_levels.led_level ||
					got_levels.fan_level !== want_levels.fan_level ||
					got_levels.diffuser_level !== want_levels.diffuser_level ||
					got_levels.heater_level !== want_levels.heater_level ||
					got_levels.is_day !== want_levels.is_day) begin
					if (mismatch_count < 10)
						$display({"mismatch: expected valve %0d led %0d fan %0d diff %0d heat %0d",
							" day %0d, got valve %0d led %0d fan %0d diff %0d heat %0d day %0d"},
							want_levels.valve_level, want_levels.led_level,
							want_levels.fan_level, want_levels.diffuser_level,
							want_levels.heater_level, want_levels.is_day,
							got_levels.valve_level, got_levels.led_level,
							got_levels.fan_level, got_levels.diffuser_level,
							got_levels.heater_level, got_levels.is_day);
					mismatch_count++;
				end
			end
		end
	end

	// Count cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin
		ghc_cfg_t    c;
		stim_row_t   row;
		int          soil, hum, temp;

		cfg_now = '{day_climate: CLIMATE_RESET, night_climate: CLIMATE_RESET,
			day_light: LIGHT_RESET, night_light: LIGHT_RESET,
			irrigation_wait_ms: IRR_WAIT_RESET, irrigation_on_ms: IRR_ON_RESET,
			irrigation_dead_ms: IRR_DEAD_RESET, light_on_time_s: ON_TIME_RESET};
		st_shift = 1'b0;
		st_wrapped = 1'b0;
		st_off_time = OFF_TIME_RESET;
		st_mark = '0;
		clear_control_flags();

		// Directed table under reset settings: soil 50.0 %, humidity 70.0 %,
		// temperature 25.0 C, light 10000 lux from 07:00:00 to 19:00:00
		row.typed = 1;
		row.tick = tick(0, 0, 0, 0, 0, 0, 100, 65535, 100, 100, 100);
		row.want = '{is_day: 1'b0, heater_level: 7'd100, diffuser_level: 7'd100,
			fan_level: 7'd100, led_level: 16'd65535, valve_level: 7'd100};
		directed_rows.push_back(row);
		row.tick = tick(25200, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		row.want = '{is_day: 1'b1, default: '0};
		directed_rows.push_back(row);
		row.tick = tick(131071, 0, 0, 0, 0, 0, 63, 21845, 42, 85, 27);
		row.want = '{is_day: 1'b0, heater_level: 7'd27, diffuser_level: 7'd85,
			fan_level: 7'd42, led_level: 16'd21845, valve_level: 7'd63};
		directed_rows.push_back(row);
		row.typed = 0;
		row.want = '0;
		// Shift edges, sensor extremes, time of day out of range
		row.tick = tick(25199, 0, 0, 850, 0, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(25200, 32'hFFFF_FFFF, 1000, -400, 1000, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(68400, 1000, 500, 260, 670, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(68401, 1000, 500, 250, 670, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(86399, 2000, 500, 250, 700, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(86400, 3000, 500, 250, 700, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		// Irrigation cycle across the millisecond wrap
		row.tick = tick(30000, WRAP_BASE_MS, 490, 250, 700, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(30001, WRAP_BASE_MS + 32'd299999, 490, 250, 700, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(30002, WRAP_BASE_MS + 32'd300000, 490, 250, 700, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(30003, WRAP_BASE_MS + 32'd309999, 490, 250, 700, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(30004, WRAP_BASE_MS + 32'd310000, 490, 250, 700, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(30005, WRAP_BASE_MS + 32'd3909999, 490, 250, 700, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(30006, WRAP_BASE_MS + 32'd3910000, 490, 250, 700, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		// Heater and diffuser bands, fan lockout of the diffuser
		row.tick = tick(40000, 5000, 500, 247, 670, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(40001, 5000, 500, 249, 690, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(40002, 5000, 500, 250, 700, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(40003, 5000, 500, 260, 600, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(40004, 5000, 500, 251, 600, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		row.tick = tick(70000, 6000, 500, 260, 600, 1, 0, 0, 0, 0, 0);
		directed_rows.push_back(row);
		// Manual mode in the middle of the day
		row.typed = 1;
		row.tick = tick(40000, 7000, 500, 250, 700, 0, 1, 2, 3, 4, 5);
		row.want = '{is_day: 1'b1, heater_level: 7'd5, diffuser_level: 7'd4,
			fan_level: 7'd3, led_level: 16'd2, valve_level: 7'd1};
		directed_rows.push_back(row);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Phase 1: reset settings, no idling
		foreach (directed_rows[k])
			send_tick(directed_rows[k].tick, directed_rows[k].typed, directed_rows[k].want);
		run_random(RANDOM_PER_PHASE, -1);
		wait_idle();

		// Phase 2: windows that pass midnight, short irrigation, sender idling
		c.day_climate = pack_climate(400, 600, 200);
		c.night_climate = pack_climate(300, 800, -50);
		c.day_light = {16'd12345, 17'd30000};
		c.night_light = {16'd54321, 17'd50000};
		c.irrigation_wait_ms = 27'd20000;
		c.irrigation_on_ms = 27'd5000;
		c.irrigation_dead_ms = 27'd60000;
		c.light_on_time_s = 17'd72000;
		apply_settings(c);
		send_idle_pct = 56;
		recv_stall_pct = 0;
		run_random(RANDOM_PER_PHASE, -1);
		wait_idle();

		// Phase 3: climate and light registers at their top, long irrigation times, late light start, receiver stalling
		c.day_climate = 31'h7FFF_FFFF;
		c.night_climate = 31'h7FFF_FFFF;
		c.day_light = 33'h1_FFFF_FFFF;
		c.night_light = 33'h1_FFFF_FFFF;
		c.irrigation_wait_ms = 27'd86400000;
		c.irrigation_on_ms = 27'd86400000;
		c.irrigation_dead_ms = 27'd86400000;
		c.light_on_time_s = 17'd86399;
		apply_settings(c);
		send_idle_pct = 0;
		recv_stall_pct = 56;
		run_random(RANDOM_PER_PHASE, -1);
		wait_idle();

		// Phase 4: bottom settings but a top day soil setpoint, zero pump time, both sides idling
		c.day_climate = {11'h400, 10'd0, 10'd1023};
		c.night_climate = '0;
		c.day_light = '0;
		c.night_light = '0;
		c.irrigation_wait_ms = '0;
		c.irrigation_on_ms = '0;
		c.irrigation_dead_ms = '0;
		c.light_on_time_s = '0;
		apply_settings(c);
		send_idle_pct = 30;
		recv_stall_pct = 30;
		run_random(RANDOM_PER_PHASE, -1);
		wait_idle();

		// Phase 5: random settings, long receiver hold-off while ticks keep coming
		soil = $urandom_range(1000);
		hum = $urandom_range(1000);
		temp = int'($urandom_range(1250)) - 400;
		c.day_climate = pack_climate(soil, hum, temp);
		c.night_climate = 31'($urandom());
		c.day_light = {16'($urandom()), 17'($urandom_range(131071))};
		c.night_light = {16'($urandom()), 17'($urandom_range(131071))};
		c.irrigation_wait_ms = 27'($urandom_range(200000));
		c.irrigation_on_ms = 27'($urandom_range(50000, 1));
		c.irrigation_dead_ms = 27'($urandom_range(400000));
		c.light_on_time_s = 17'($urandom_range(86399));
		apply_settings(c);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random(RANDOM_PER_PHASE, 100);
		wait_idle();

		// Let any stray result show up before the verdict
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_levels.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: greenhouse_hysteresis_controller.f
rtl/ghc_pkg.sv
rtl/ghc_cfg_regs.sv
rtl/ghc_core.sv
rtl/greenhouse_hysteresis_controller.sv
verif/tb_greenhouse_hysteresis_controller.sv
